[hdl/gbt_pkg.sv]
// Shared types and constants for the graph traversal engine.
// No dependencies; every other file in hdl/ but gbt_ram imports this package.
package gbt_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int VTX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int EIDX_W       = 8;
    localparam int PTR_W        = 9;
    localparam int ENTRY_W      = VTX_W + PTR_W;

    // End-of-list pointer value
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(MAX_EDGES);

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TRAV = 1'b1;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TRAV = 1'b1;

    localparam logic MODE_BFS = 1'b0;
    localparam logic MODE_DFS = 1'b1;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_START = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ADD_RD, ST_ADD_WR, ST_BFS_INIT, ST_BFS_POP, ST_BFS_POPW,
        ST_BFS_HEAD, ST_BFS_EDGE, ST_BFS_EDGEW, ST_DFS_ROOT, ST_DFS_RHEAD,
        ST_DFS_TOP, ST_DFS_POPW, ST_DFS_EDGEW, ST_DFS_PUSHW, ST_FLUSH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_ADD_RD, OP_ADD_WR, OP_BFS_INIT, OP_BFS_POP,
        OP_BFS_POPW, OP_BFS_HEAD, OP_BFS_EDGE, OP_BFS_EDGEW, OP_DFS_ROOT,
        OP_DFS_RHEAD, OP_DFS_TOP, OP_DFS_POPW, OP_DFS_EDGEW, OP_DFS_PUSHW,
        OP_FLUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic mode;
        logic start_bad;
        logic q_empty;
        logic e_null;
        logic root_done;
        logic root_visited;
        logic top_null;
        logic sp_one;
        logic push_ok;
    } dp_stat_t;

endpackage

[hdl/graph_bfs_dfs_traversal.sv]
// Directed graph store with breadth-first and depth-first traversal.
// Add edge: the request steps through ADD_RD and ADD_WR, then the result is registered.
// BFS and DFS step through their states around the registered reads of the stores;
// a BFS with an out-of-range start vertex ends after BFS_INIT with a range result.
// Results strobe one cycle, no stall.
// Reset clears the graph (all lists empty) and the control registers; no sweep needed.
module graph_bfs_dfs_traversal (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      req_type,
    input  logic [gbt_pkg::VTX_W-1:0] src_vertex,
    input  logic [gbt_pkg::VTX_W-1:0] dst_vertex,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [gbt_pkg::CNT_W-1:0] cfg_data,
    output logic                      result_valid,
    output logic                      result_kind,
    output logic [1:0]                status,
    output logic [gbt_pkg::VTX_W-1:0] vertex,
    output logic [gbt_pkg::VTX_W-1:0] level,
    output logic                      last_item
);
    import gbt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    gbt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .req_type(req_type),
        .stat(stat), .cmd(cmd), .busy(busy)
    );

    // Storage and result path
    gbt_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .src_vertex(src_vertex), .dst_vertex(dst_vertex),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result_valid(result_valid), .result_kind(result_kind),
        .status(status), .vertex(vertex), .level(level),
        .last_item(last_item)
    );

endmodule

[hdl/gbt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/gbt_ctrl.sv]
// Sequencing state machine of the traversal engine.
// Depends on gbt_pkg; drives gbt_dp through command and status structs.
module gbt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              req_type,
    input  gbt_pkg::dp_stat_t stat,
    output gbt_pkg::dp_cmd_t  cmd,
    output logic              busy
);
    import gbt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_ADD)
                        state_next = ST_ADD_RD;
                    else if (stat.mode == MODE_DFS)
                        state_next = ST_DFS_ROOT;
                    else
                        state_next = ST_BFS_INIT;
                end
            end
            ST_ADD_RD:    state_next = ST_ADD_WR;
            ST_ADD_WR:    state_next = ST_IDLE;
            ST_BFS_INIT:  state_next = stat.start_bad ? ST_IDLE : ST_BFS_POP;
            ST_BFS_POP:   state_next = stat.q_empty ? ST_FLUSH : ST_BFS_POPW;
            ST_BFS_POPW:  state_next = ST_BFS_HEAD;
            ST_BFS_HEAD:  state_next = ST_BFS_EDGE;
            ST_BFS_EDGE:  state_next = stat.e_null ? ST_BFS_POP : ST_BFS_EDGEW;
            ST_BFS_EDGEW: state_next = ST_BFS_EDGE;
            ST_DFS_ROOT:
            begin
                if (stat.root_done)
                    state_next = ST_FLUSH;
                else if (!stat.root_visited)
                    state_next = ST_DFS_RHEAD;
            end
            ST_DFS_RHEAD: state_next = ST_DFS_TOP;
            ST_DFS_TOP:
            begin
                if (!stat.top_null)
                    state_next = ST_DFS_EDGEW;
                else if (stat.sp_one)
                    state_next = ST_DFS_ROOT;
                else
                    state_next = ST_DFS_POPW;
            end
            ST_DFS_POPW:  state_next = ST_DFS_TOP;
            ST_DFS_EDGEW: state_next = stat.push_ok ? ST_DFS_PUSHW : ST_DFS_TOP;
            ST_DFS_PUSHW: state_next = ST_DFS_TOP;
            ST_FLUSH:     state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            ST_IDLE:      cmd.op = start ? OP_ACCEPT : OP_NONE;
            ST_ADD_RD:    cmd.op = OP_ADD_RD;
            ST_ADD_WR:    cmd.op = OP_ADD_WR;
            ST_BFS_INIT:  cmd.op = OP_BFS_INIT;
            ST_BFS_POP:   cmd.op = OP_BFS_POP;
            ST_BFS_POPW:  cmd.op = OP_BFS_POPW;
            ST_BFS_HEAD:  cmd.op = OP_BFS_HEAD;
            ST_BFS_EDGE:  cmd.op = OP_BFS_EDGE;
            ST_BFS_EDGEW: cmd.op = OP_BFS_EDGEW;
            ST_DFS_ROOT:  cmd.op = OP_DFS_ROOT;
            ST_DFS_RHEAD: cmd.op = OP_DFS_RHEAD;
            ST_DFS_TOP:   cmd.op = OP_DFS_TOP;
            ST_DFS_POPW:  cmd.op = OP_DFS_POPW;
            ST_DFS_EDGEW: cmd.op = OP_DFS_EDGEW;
            ST_DFS_PUSHW: cmd.op = OP_DFS_PUSHW;
            ST_FLUSH:     cmd.op = OP_FLUSH;
            default:      cmd.op = OP_NONE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[hdl/gbt_dp.sv]
// Datapath of the traversal engine: registers, list heads, edge store,
// queue/stack store and the result register. Depends on gbt_pkg, gbt_ram.
module gbt_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gbt_pkg::dp_cmd_t            cmd,
    output gbt_pkg::dp_stat_t           stat,
    input  logic [gbt_pkg::VTX_W-1:0]   src_vertex,
    input  logic [gbt_pkg::VTX_W-1:0]   dst_vertex,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [gbt_pkg::CNT_W-1:0]   cfg_data,
    output logic                        result_valid,
    output logic                        result_kind,
    output logic [1:0]                  status,
    output logic [gbt_pkg::VTX_W-1:0]   vertex,
    output logic [gbt_pkg::VTX_W-1:0]   level,
    output logic                        last_item
);
    import gbt_pkg::*;

    logic                    mode_reg, mode_next;
    logic [CNT_W-1:0]        vcount_reg, vcount_next;
    logic [VTX_W-1:0]        start_reg, start_next;
    logic [VTX_W-1:0]        src_reg, src_next;
    logic [VTX_W-1:0]        dst_reg, dst_next;
    logic [PTR_W-1:0]        edges_used_reg, edges_used_next;
    logic [MAX_VERTICES-1:0] head_vld_reg, head_vld_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic                    hv_q_reg, hv_q_next;
    logic [CNT_W-1:0]        qhead_reg, qhead_next;
    logic [CNT_W-1:0]        tail_reg, tail_next;
    logic [CNT_W-1:0]        root_reg, root_next;
    logic [CNT_W-1:0]        sp_reg, sp_next;
    logic [VTX_W-1:0]        cur_lv_reg, cur_lv_next;
    logic [PTR_W-1:0]        e_reg, e_next;
    logic [VTX_W-1:0]        top_v_reg, top_v_next;
    logic [PTR_W-1:0]        top_e_reg, top_e_next;
    logic                    pend_vld_reg, pend_vld_next;
    logic [VTX_W-1:0]        pend_v_reg, pend_v_next;
    logic [VTX_W-1:0]        pend_lv_reg, pend_lv_next;
    logic                    rv_reg, rv_next;
    logic                    rk_reg, rk_next;
    logic [1:0]              rs_reg, rs_next;
    logic [VTX_W-1:0]        rvx_reg, rvx_next;
    logic [VTX_W-1:0]        rl_reg, rl_next;
    logic                    rlast_reg, rlast_next;

    logic [CNT_W-1:0]   cnt;
    logic [PTR_W-1:0]   head_val;
    logic [1:0]         add_status;
    logic [VTX_W-1:0]   e_tgt;
    logic [PTR_W-1:0]   e_lnk;
    logic [VTX_W-1:0]   w_vtx;
    logic [PTR_W-1:0]   w_aux;
    logic               tgt_new;
    logic               produce;
    logic [VTX_W-1:0]   prod_v;
    logic [VTX_W-1:0]   prod_lv;
    logic [VTX_W-1:0]   lv_inc;

    logic               h_we;
    logic [VTX_W-1:0]   h_waddr;
    logic [PTR_W-1:0]   h_wdata;
    logic [VTX_W-1:0]   h_raddr;
    logic [PTR_W-1:0]   h_rd;
    logic               e_we;
    logic [EIDX_W-1:0]  e_waddr;
    logic [ENTRY_W-1:0] e_wdata;
    logic [EIDX_W-1:0]  e_raddr;
    logic [ENTRY_W-1:0] e_rd;
    logic               w_we;
    logic [VTX_W-1:0]   w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [VTX_W-1:0]   w_raddr;
    logic [ENTRY_W-1:0] w_rd;

    // Neighbor list heads, edge store and queue/stack store
    gbt_ram #(.WIDTH(PTR_W), .DEPTH(MAX_VERTICES)) u_head_ram (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rd)
    );

    gbt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rd)
    );

    gbt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTICES)) u_work_ram (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rd)
    );

    // Clamp the vertex count into its working range
    always_comb
    begin
        priority if (vcount_reg == '0)
            cnt = CNT_W'(1);
        else if (vcount_reg > CNT_W'(MAX_VERTICES))
            cnt = CNT_W'(MAX_VERTICES);
        else
            cnt = vcount_reg;
    end

    // Decode read data
    assign head_val = hv_q_reg ? h_rd : NULL_PTR;
    assign e_tgt    = e_rd[ENTRY_W-1:PTR_W];
    assign e_lnk    = e_rd[PTR_W-1:0];
    assign w_vtx    = w_rd[ENTRY_W-1:PTR_W];
    assign w_aux    = w_rd[PTR_W-1:0];
    assign tgt_new  = ({1'b0, e_tgt} < cnt) && !visited_reg[e_tgt];
    assign lv_inc   = cur_lv_reg + VTX_W'(1);

    always_comb
    begin
        priority if (({1'b0, src_reg} >= cnt) || ({1'b0, dst_reg} >= cnt))
            add_status = STAT_RANGE;
        else if (edges_used_reg >= PTR_W'(MAX_EDGES))
            add_status = STAT_FULL;
        else
            add_status = STAT_OK;
    end

    // Status to the controller
    always_comb
    begin
        stat.mode         = mode_reg;
        stat.start_bad    = ({1'b0, start_reg} >= cnt);
        stat.q_empty      = (qhead_reg == tail_reg);
        stat.e_null       = (e_reg >= NULL_PTR);
        stat.root_done    = (root_reg >= cnt);
        stat.root_visited = visited_reg[root_reg[VTX_W-1:0]];
        stat.top_null     = (top_e_reg >= NULL_PTR);
        stat.sp_one       = (sp_reg == CNT_W'(1));
        stat.push_ok      = tgt_new && (sp_reg < CNT_W'(MAX_VERTICES));
    end

    // Next-state logic for all datapath registers
    always_comb
    begin
        mode_next       = mode_reg;
        vcount_next     = vcount_reg;
        start_next      = start_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        edges_used_next = edges_used_reg;
        head_vld_next   = head_vld_reg;
        visited_next    = visited_reg;
        qhead_next      = qhead_reg;
        tail_next       = tail_reg;
        root_next       = root_reg;
        sp_next         = sp_reg;
        cur_lv_next     = cur_lv_reg;
        e_next          = e_reg;
        top_v_next      = top_v_reg;
        top_e_next      = top_e_reg;
        pend_vld_next   = pend_vld_reg;
        pend_v_next     = pend_v_reg;
        pend_lv_next    = pend_lv_reg;
        rv_next         = 1'b0;
        rk_next         = rk_reg;
        rs_next         = rs_reg;
        rvx_next        = rvx_reg;
        rl_next         = rl_reg;
        rlast_next      = rlast_reg;
        produce         = 1'b0;
        prod_v          = '0;
        prod_lv         = '0;
        h_we            = 1'b0;
        h_waddr         = src_reg;
        h_wdata         = edges_used_reg;
        h_raddr         = src_reg;
        e_we            = 1'b0;
        e_waddr         = edges_used_reg[EIDX_W-1:0];
        e_wdata         = {dst_reg, head_val};
        e_raddr         = e_reg[EIDX_W-1:0];
        w_we            = 1'b0;
        w_waddr         = tail_reg[VTX_W-1:0];
        w_wdata         = {e_tgt, PTR_W'(lv_inc)};
        w_raddr         = qhead_reg[VTX_W-1:0];

        // Take configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:  mode_next   = cfg_data[0];
                REG_COUNT: vcount_next = cfg_data;
                REG_START: start_next  = cfg_data[VTX_W-1:0];
                default:   ;
            endcase
        end

        unique case (cmd.op)
            OP_ACCEPT:
            begin
                src_next      = src_vertex;
                dst_next      = dst_vertex;
                visited_next  = '0;
                pend_vld_next = 1'b0;
                root_next     = '0;
            end
            OP_ADD_RD:
            begin
                h_raddr = src_reg;
            end
            OP_ADD_WR:
            begin
                rv_next    = 1'b1;
                rk_next    = KIND_ADD;
                rs_next    = add_status;
                rvx_next   = '0;
                rl_next    = '0;
                rlast_next = 1'b1;
                if (add_status == STAT_OK)
                begin
                    e_we                   = 1'b1;
                    h_we                   = 1'b1;
                    head_vld_next[src_reg] = 1'b1;
                    edges_used_next        = edges_used_reg + PTR_W'(1);
                end
            end
            OP_BFS_INIT:
            begin
                if (stat.start_bad)
                begin
                    rv_next    = 1'b1;
                    rk_next    = KIND_TRAV;
                    rs_next    = STAT_RANGE;
                    rvx_next   = start_reg;
                    rl_next    = '0;
                    rlast_next = 1'b1;
                end
                else
                begin
                    visited_next[start_reg] = 1'b1;
                    w_we       = 1'b1;
                    w_waddr    = '0;
                    w_wdata    = {start_reg, PTR_W'(0)};
                    qhead_next = '0;
                    tail_next  = CNT_W'(1);
                    produce    = 1'b1;
                    prod_v     = start_reg;
                end
            end
            OP_BFS_POP:
            begin
                w_raddr = qhead_reg[VTX_W-1:0];
                if (!stat.q_empty)
                    qhead_next = qhead_reg + CNT_W'(1);
            end
            OP_BFS_POPW:
            begin
                cur_lv_next = w_aux[VTX_W-1:0];
                h_raddr     = w_vtx;
            end
            OP_BFS_HEAD:
            begin
                e_next = head_val;
            end
            OP_BFS_EDGE:
            begin
                e_raddr = e_reg[EIDX_W-1:0];
            end
            OP_BFS_EDGEW:
            begin
                e_next = e_lnk;
                if (tgt_new && (tail_reg < CNT_W'(MAX_VERTICES)))
                begin
                    visited_next[e_tgt] = 1'b1;
                    w_we      = 1'b1;
                    w_waddr   = tail_reg[VTX_W-1:0];
                    w_wdata   = {e_tgt, PTR_W'(lv_inc)};
                    tail_next = tail_reg + CNT_W'(1);
                    produce   = 1'b1;
                    prod_v    = e_tgt;
                    prod_lv   = lv_inc;
                end
            end
            OP_DFS_ROOT:
            begin
                h_raddr = root_reg[VTX_W-1:0];
                if (!stat.root_done && !stat.root_visited)
                    visited_next[root_reg[VTX_W-1:0]] = 1'b1;
                if (!stat.root_done && stat.root_visited)
                    root_next = root_reg + CNT_W'(1);
            end
            OP_DFS_RHEAD:
            begin
                top_v_next = root_reg[VTX_W-1:0];
                top_e_next = head_val;
                sp_next    = CNT_W'(1);
                root_next  = root_reg + CNT_W'(1);
            end
            OP_DFS_TOP:
            begin
                e_raddr = top_e_reg[EIDX_W-1:0];
                w_raddr = VTX_W'(sp_reg - CNT_W'(2));
                if (stat.top_null)
                begin
                    produce = 1'b1;
                    prod_v  = top_v_reg;
                    sp_next = sp_reg - CNT_W'(1);
                end
            end
            OP_DFS_POPW:
            begin
                top_v_next = w_vtx;
                top_e_next = w_aux;
            end
            OP_DFS_EDGEW:
            begin
                top_e_next = e_lnk;
                if (stat.push_ok)
                begin
                    visited_next[e_tgt] = 1'b1;
                    w_we       = 1'b1;
                    w_waddr    = VTX_W'(sp_reg - CNT_W'(1));
                    w_wdata    = {top_v_reg, e_lnk};
                    top_v_next = e_tgt;
                    h_raddr    = e_tgt;
                    sp_next    = sp_reg + CNT_W'(1);
                end
            end
            OP_DFS_PUSHW:
            begin
                top_e_next = head_val;
            end
            OP_FLUSH:
            begin
                if (pend_vld_reg)
                begin
                    rv_next       = 1'b1;
                    rk_next       = KIND_TRAV;
                    rs_next       = STAT_OK;
                    rvx_next      = pend_v_reg;
                    rl_next       = pend_lv_reg;
                    rlast_next    = 1'b1;
                    pend_vld_next = 1'b0;
                end
            end
            default: ;
        endcase

        // Hold one report back so the final one can carry the last mark
        if (produce)
        begin
            if (pend_vld_reg)
            begin
                rv_next    = 1'b1;
                rk_next    = KIND_TRAV;
                rs_next    = STAT_OK;
                rvx_next   = pend_v_reg;
                rl_next    = pend_lv_reg;
                rlast_next = 1'b0;
            end
            pend_vld_next = 1'b1;
            pend_v_next   = prod_v;
            pend_lv_next  = prod_lv;
        end

        hv_q_next = head_vld_reg[h_raddr];
    end

    // Update control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_BFS;
            vcount_reg     <= CNT_W'(MAX_VERTICES);
            start_reg      <= '0;
            edges_used_reg <= '0;
            head_vld_reg   <= '0;
            visited_reg    <= '0;
            hv_q_reg       <= 1'b0;
            qhead_reg      <= '0;
            tail_reg       <= '0;
            root_reg       <= '0;
            sp_reg         <= '0;
            pend_vld_reg   <= 1'b0;
            rv_reg         <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            vcount_reg     <= vcount_next;
            start_reg      <= start_next;
            edges_used_reg <= edges_used_next;
            head_vld_reg   <= head_vld_next;
            visited_reg    <= visited_next;
            hv_q_reg       <= hv_q_next;
            qhead_reg      <= qhead_next;
            tail_reg       <= tail_next;
            root_reg       <= root_next;
            sp_reg         <= sp_next;
            pend_vld_reg   <= pend_vld_next;
            rv_reg         <= rv_next;
        end
    end

    // Update payload registers
    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        cur_lv_reg  <= cur_lv_next;
        e_reg       <= e_next;
        top_v_reg   <= top_v_next;
        top_e_reg   <= top_e_next;
        pend_v_reg  <= pend_v_next;
        pend_lv_reg <= pend_lv_next;
        rk_reg      <= rk_next;
        rs_reg      <= rs_next;
        rvx_reg     <= rvx_next;
        rl_reg      <= rl_next;
        rlast_reg   <= rlast_next;
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = rv_reg;
    assign result_kind  = rk_reg;
    assign status       = rs_reg;
    assign vertex       = rvx_reg;
    assign level        = rl_reg;
    assign last_item    = rlast_reg;

endmodule

[test/tb_graph_bfs_dfs_traversal.sv]
// Testbench for graph_bfs_dfs_traversal: loads random directed edges and runs BFS/DFS walks.
// A scoreboard class predicts every report from its own copy of the graph; needs gbt_pkg and the design.
`timescale 1ns / 1ps

module tb_graph_bfs_dfs_traversal;
    import gbt_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [1:0] stat;
        logic [5:0] vtx;
        logic [5:0] lvl;
        logic       last;
    } gbt_result_t;

    class graph_scoreboard;
        logic        mode;
        logic [6:0]  vcount;
        logic [5:0]  root;
        int          head_ptr[MAX_VERTICES];
        int          tgt[MAX_EDGES];
        int          nxt[MAX_EDGES];
        int          used;
        bit          seen[MAX_VERTICES];
        gbt_result_t pending[$];

        function new();
            mode = MODE_BFS;
            vcount = 7'd64;
            root = 6'd0;
            used = 0;
            foreach (head_ptr[i]) head_ptr[i] = MAX_EDGES;
        endfunction

        function void set_reg(logic [1:0] idx, logic [6:0] data);
            if (idx == REG_MODE) mode = data[0];
            else if (idx == REG_COUNT) vcount = data;
            else if (idx == REG_START) root = data[5:0];
        endfunction

        function void push_report(logic [5:0] v, logic [5:0] l);
            gbt_result_t r;
            r.kind = KIND_TRAV;
            r.stat = STAT_OK;
            r.vtx = v;
            r.lvl = l;
            r.last = 1'b0;
            pending.push_back(r);
        endfunction

        // Note one accepted request and queue what it must produce
        function void note_request(logic rq, logic [5:0] src, logic [5:0] dst);
            int cnt;
            int wv[MAX_VERTICES];
            int wa[MAX_VERTICES];
            int qh;
            int qt;
            int e;
            int v;
            int sp;
            int first;
            gbt_result_t r;
            cnt = (vcount == 0) ? 1 : ((vcount > MAX_VERTICES) ? MAX_VERTICES : vcount);
            first = pending.size();
            if (rq == REQ_ADD)
            begin
                r = '0;
                r.kind = KIND_ADD;
                r.last = 1'b1;
                if (src >= cnt || dst >= cnt) r.stat = STAT_RANGE;
                else if (used >= MAX_EDGES) r.stat = STAT_FULL;
                else
                begin
                    tgt[used] = dst;
                    nxt[used] = head_ptr[src];
                    head_ptr[src] = used;
                    used++;
                    r.stat = STAT_OK;
                end
                pending.push_back(r);
                return;
            end
            foreach (seen[i]) seen[i] = 0;
            if (mode == MODE_BFS)
            begin
                if (root >= cnt)
                begin
                    r = '0;
                    r.kind = KIND_TRAV;
                    r.stat = STAT_RANGE;
                    r.vtx = root;
                    r.last = 1'b1;
                    pending.push_back(r);
                    return;
                end
                seen[root] = 1;
                wv[0] = root;
                wa[0] = 0;
                qh = 0;
                qt = 1;
                push_report(root, 6'd0);
                while (qh < qt)
                begin
                    e = head_ptr[wv[qh]];
                    while (e < MAX_EDGES)
                    begin
                        v = tgt[e];
                        if (v < cnt && !seen[v] && qt < MAX_VERTICES)
                        begin
                            seen[v] = 1;
                            wv[qt] = v;
                            wa[qt] = wa[qh] + 1;
                            push_report(v[5:0], 6'(wa[qt]));
                            qt++;
                        end
                        e = nxt[e];
                    end
                    qh++;
                end
            end
            else
            begin
                for (int rt = 0; rt < cnt; rt++)
                begin
                    if (seen[rt]) continue;
                    seen[rt] = 1;
                    wv[0] = rt;
                    wa[0] = head_ptr[rt];
                    sp = 1;
                    while (sp > 0)
                    begin
                        e = wa[sp-1];
                        if (e >= MAX_EDGES)
                        begin
                            push_report(6'(wv[sp-1]), 6'd0);
                            sp--;
                        end
                        else
                        begin
                            v = tgt[e];
                            wa[sp-1] = nxt[e];
                            if (v < cnt && !seen[v] && sp < MAX_VERTICES)
                            begin
                                seen[v] = 1;
                                wv[sp] = v;
                                wa[sp] = head_ptr[v];
                                sp++;
                            end
                        end
                    end
                end
            end
            if (pending.size() > first) pending[pending.size()-1].last = 1'b1;
        endfunction

        // Compare one strobed result with the oldest expectation
        function bit check_result(gbt_result_t got, output string msg);
            gbt_result_t exp_r;
            if (pending.size() == 0)
            begin
                msg = $sformatf("unexpected result %p", got);
                return 0;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r)
            begin
                msg = $sformatf("got %p, wanted %p", got, exp_r);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       req_type;
    logic [5:0] src_vertex;
    logic [5:0] dst_vertex;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [6:0] cfg_data;
    logic       result_valid;
    logic       result_kind;
    logic [1:0] status;
    logic [5:0] vertex;
    logic [5:0] level;
    logic       last_item;

    graph_scoreboard board;
    int errors;
    int reports_seen;

    graph_bfs_dfs_traversal i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .src_vertex(src_vertex), .dst_vertex(dst_vertex),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .result_kind(result_kind),
        .status(status), .vertex(vertex), .level(level), .last_item(last_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    // Check each strobed result at the edge that ends its cycle
    always @(posedge clk)
    begin
        gbt_result_t got;
        string msg;
        if (rst_n && result_valid)
        begin
            got = {result_kind, status, vertex, level, last_item};
            reports_seen++;
            if (!board.check_result(got, msg)) report_mismatch(msg);
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        repeat (n) @(posedge clk);
    endtask

    // Wait until every expected result has come, then let the block settle
    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Hold one register write for a transfer, then drop valid for a cycle
    task automatic write_reg(logic [1:0] idx, logic [6:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold a request until the block takes it, then drop start for a cycle
    task automatic send_request(logic rq, logic [5:0] src, logic [5:0] dst);
        start <= 1'b1;
        req_type <= rq;
        src_vertex <= src;
        dst_vertex <= dst;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_request(rq, src, dst);
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic traverse(logic m, logic [6:0] cnt, logic [5:0] rt);
        drain();
        write_reg(REG_MODE, {6'd0, m});
        write_reg(REG_COUNT, cnt);
        write_reg(REG_START, rt);
        send_request(REQ_TRAV, 6'($urandom), 6'($urandom));
        drain();
    endtask

    initial
    begin
        logic [6:0] cnt;
        board = new();
        errors = 0;
        reports_seen = 0;
        start = 1'b0;
        req_type = REQ_ADD;
        src_vertex = '0;
        dst_vertex = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty graph walks, range errors, extremes of the fields
        send_request(REQ_TRAV, 6'd0, 6'd0);
        drain();
        write_reg(REG_MODE, {6'd0, MODE_DFS});
        send_request(REQ_TRAV, 6'd63, 6'd63);
        drain();
        write_reg(REG_COUNT, 7'd0);
        send_request(REQ_ADD, 6'd0, 6'd0);
        send_request(REQ_ADD, 6'd0, 6'd1);
        send_request(REQ_TRAV, 6'd0, 6'd0);
        traverse(MODE_BFS, 7'd127, 6'd63);
        traverse(MODE_BFS, 7'd10, 6'd20);
        send_request(REQ_ADD, 6'd63, 6'd0);
        send_request(REQ_ADD, 6'd0, 6'd63);
        send_request(REQ_ADD, 6'd63, 6'd63);
        drain();
        write_reg(REG_COUNT, 7'd64);
        send_request(REQ_ADD, 6'd63, 6'd0);
        send_request(REQ_ADD, 6'd0, 6'd63);
        send_request(REQ_ADD, 6'd0, 6'd1);
        send_request(REQ_ADD, 6'd1, 6'd0);
        send_request(REQ_ADD, 6'd63, 6'd63);
        traverse(MODE_BFS, 7'd64, 6'd0);
        traverse(MODE_DFS, 7'd64, 6'd5);
        // Lowered count skips edges to high vertices
        traverse(MODE_BFS, 7'd2, 6'd0);
        traverse(MODE_DFS, 7'd1, 6'd0);

        // Random: phases of edge loading with walks between, count set per phase
        for (int ph = 0; ph < 12; ph++)
        begin
            drain();
            cnt = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(2, 64));
            write_reg(REG_COUNT, cnt);
            for (int k = 0; k < 10; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_request(REQ_ADD, 6'($urandom), 6'($urandom));
                else
                    send_request(REQ_ADD, 6'($urandom_range(0, 63) % (cnt == 0 ? 1 : cnt)),
                                 6'($urandom_range(0, 63) % (cnt == 0 ? 1 : cnt)));
                idle_gap();
            end
            traverse(1'($urandom), cnt, 6'($urandom_range(0, 7) == 0 ? $urandom
                      : $urandom_range(0, 63) % (cnt == 0 ? 1 : cnt)));
            traverse(1'($urandom), 7'($urandom_range(1, 64)), 6'($urandom));
        end
        // Walk the densest graph built so far
        traverse(MODE_BFS, 7'd64, 6'($urandom));
        traverse(MODE_DFS, 7'd64, 6'd0);
        traverse(MODE_BFS, 7'd64, 6'd63);

        drain();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

[sim.f]
hdl/gbt_pkg.sv
hdl/gbt_ram.sv
hdl/gbt_ctrl.sv
hdl/gbt_dp.sv
hdl/graph_bfs_dfs_traversal.sv
test/tb_graph_bfs_dfs_traversal.sv
